FILE: rtl/stt_ring_pkg.sv
`default_nettype none
package stt_ring_pkg;

   localparam int SLOTS_MAX_DEF = 1024;
   localparam int CAP_W = 11;
   localparam int SEQ_W = 64;
   localparam int BODY_W = 64;
   localparam int REQ_W = 3;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [REQ_W-1:0] {
      REQ_EMIT    = 3'd0,
      REQ_READ    = 3'd1,
      REQ_OLDEST  = 3'd2,
      REQ_GAP     = 3'd3,
      REQ_RESTORE = 3'd4
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_RD,
      ST_RDWAIT,
      ST_CHECK,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Request to the remainder unit and its answer.
   typedef struct packed {
      logic             go;
      logic [SEQ_W-1:0] dividend;
      logic [CAP_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic             done;
      logic [CAP_W-1:0] rem;
   } rem_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/sequence_tagged_trace_ring_core.sv
`default_nettype none
// Steps to the result: emit and read run the 64-step remainder, a memory read and a check;
// dropped emit, zero-capacity read, oldest retained and unused codes go straight to done;
// gap check repeats them per slot walked; restore runs the valid clearing sweep.
// Throughput: one item at a time; busy drops in the result cycle, which can accept the next.
// Each result shows for one cycle with rsp_valid; the receiver cannot stall. Reset is
// synchronous and is followed by a valid clearing sweep over all slots with busy high.
module sequence_tagged_trace_ring_core #(
   parameter int SLOTS_MAX = stt_ring_pkg::SLOTS_MAX_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic [stt_ring_pkg::REQ_W-1:0]     req_type,
   input  wire logic [stt_ring_pkg::BODY_W-1:0]    req_record_body,
   input  wire logic                               req_record_ok,
   input  wire logic [stt_ring_pkg::SEQ_W-1:0]     req_sequence_arg,
   input  wire logic [stt_ring_pkg::SEQ_W-1:0]     req_span_count,
   input  wire logic                               csr_we,
   input  wire logic [stt_ring_pkg::CAP_W-1:0]     csr_ring_capacity,
   output      logic                               rsp_valid,
   output      logic                               rsp_ok,
   output      logic [stt_ring_pkg::SEQ_W-1:0]     rsp_issued_seq,
   output      logic [stt_ring_pkg::BODY_W-1:0]    rsp_read_body,
   output      logic [stt_ring_pkg::SEQ_W-1:0]     rsp_oldest_retained,
   output      logic [stt_ring_pkg::SEQ_W-1:0]     rsp_emitted_total,
   output      logic [stt_ring_pkg::SEQ_W-1:0]     rsp_overwritten_total,
   output      logic [stt_ring_pkg::SEQ_W-1:0]     rsp_dropped_total
);
   localparam int SW = stt_ring_pkg::SEQ_W;
   localparam int CW = stt_ring_pkg::CAP_W;
   localparam int AW = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
   localparam logic [SW-1:0] ALL_ONES = '1;

   // Slot memories: valid bits, tags, bodies.
   logic          valid_mem [SLOTS_MAX];
   logic [SW-1:0] tag_mem   [SLOTS_MAX];
   logic [SW-1:0] body_mem  [SLOTS_MAX];
   logic          rd_valid_ff;
   logic [SW-1:0] rd_tag_ff, rd_body_ff;

   stt_ring_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cap_ff;
   logic [SW-1:0] next_seq_ff, next_seq_in;
   logic [SW-1:0] emit_cnt_ff, emit_cnt_in, ovw_cnt_ff, ovw_cnt_in, drop_cnt_ff, drop_cnt_in;
   localparam int REQ_W_L = stt_ring_pkg::REQ_W;
   logic [REQ_W_L-1:0] op_ff, op_in;
   logic [SW-1:0] body_ff, body_in, seq_ff, seq_in, left_ff, left_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW:0]   clr_ff, clr_in;
   logic          res_ok_ff, res_ok_in;
   logic [SW-1:0] res_asg_ff, res_asg_in, res_body_ff, res_body_in, res_old_ff, res_old_in;
   logic          out_v_ff, out_v_in;

   logic          mem_we, mem_rd, vclr_we;
   logic [AW-1:0] vclr_idx;
   logic [CW-1:0] cap_use;
   logic [SW-1:0] cap_ext;
   logic [SW:0]   span_end;

   stt_ring_pkg::rem_req_type rem_req;
   stt_ring_pkg::rem_rsp_type rem_rsp;

   stt_ring_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   assign cap_use  = ({21'd0, cap_ff} > 32'(SLOTS_MAX)) ? CW'(SLOTS_MAX) : cap_ff;
   assign cap_ext  = SW'(cap_use);
   assign span_end = {1'b0, req_sequence_arg} + {1'b0, req_span_count};
   assign busy     = (state_ff != stt_ring_pkg::ST_IDLE);

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= stt_ring_pkg::CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_ring_capacity;
      end
   end

   // Sequencer: next state, datapath and memory controls.
   always_comb begin
      state_in    = state_ff;
      next_seq_in = next_seq_ff;
      emit_cnt_in = emit_cnt_ff;
      ovw_cnt_in  = ovw_cnt_ff;
      drop_cnt_in = drop_cnt_ff;
      op_in       = op_ff;
      body_in     = body_ff;
      seq_in      = seq_ff;
      left_in     = left_ff;
      idx_in      = idx_ff;
      clr_in      = clr_ff;
      res_ok_in   = res_ok_ff;
      res_asg_in  = res_asg_ff;
      res_body_in = res_body_ff;
      res_old_in  = res_old_ff;
      out_v_in    = 1'b0;
      mem_we      = 1'b0;
      mem_rd      = 1'b0;
      vclr_we     = 1'b0;
      vclr_idx    = clr_ff[AW-1:0];
      rem_req.go       = 1'b0;
      rem_req.dividend = seq_ff;
      rem_req.divisor  = cap_use;
      unique case (state_ff)
         stt_ring_pkg::ST_IDLE: begin
            if (start) begin
               op_in       = req_type;
               body_in     = req_record_body;
               res_ok_in   = 1'b0;
               res_asg_in  = '0;
               res_body_in = '0;
               res_old_in  = '0;
               state_in    = stt_ring_pkg::ST_DONE;
               case (req_type)
                  stt_ring_pkg::REQ_EMIT: begin
                     res_asg_in = next_seq_ff;
                     seq_in     = next_seq_ff;
                     if (next_seq_ff == ALL_ONES) begin
                        drop_cnt_in = drop_cnt_ff + 1'b1;
                     end else begin
                        next_seq_in = next_seq_ff + 1'b1;
                        if (!req_record_ok || cap_use == '0) begin
                           drop_cnt_in = drop_cnt_ff + 1'b1;
                        end else begin
                           rem_req.go       = 1'b1;
                           rem_req.dividend = next_seq_ff;
                           state_in         = stt_ring_pkg::ST_DIV;
                        end
                     end
                  end
                  stt_ring_pkg::REQ_READ: begin
                     seq_in  = req_sequence_arg;
                     left_in = SW'(1);
                     if (cap_use != '0) begin
                        rem_req.go       = 1'b1;
                        rem_req.dividend = req_sequence_arg;
                        state_in         = stt_ring_pkg::ST_DIV;
                     end
                  end
                  stt_ring_pkg::REQ_OLDEST: begin
                     res_old_in = (req_sequence_arg > cap_ext) ?
                                  req_sequence_arg - cap_ext : '0;
                  end
                  stt_ring_pkg::REQ_GAP: begin
                     seq_in  = req_sequence_arg;
                     left_in = req_span_count;
                     if (span_end[SW]) begin
                        res_ok_in = 1'b0;
                     end else if (req_span_count > cap_ext) begin
                        res_ok_in = 1'b0;
                     end else if (req_span_count == '0) begin
                        res_ok_in = 1'b1;
                     end else begin
                        rem_req.go       = 1'b1;
                        rem_req.dividend = req_sequence_arg;
                        state_in         = stt_ring_pkg::ST_DIV;
                     end
                  end
                  stt_ring_pkg::REQ_RESTORE: begin
                     next_seq_in = req_sequence_arg;
                     emit_cnt_in = '0;
                     ovw_cnt_in  = '0;
                     drop_cnt_in = '0;
                     clr_in      = '0;
                     state_in    = stt_ring_pkg::ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         stt_ring_pkg::ST_DIV: begin
            if (rem_rsp.done) begin
               idx_in   = AW'(rem_rsp.rem);
               state_in = stt_ring_pkg::ST_RD;
            end
         end
         stt_ring_pkg::ST_RD: begin
            mem_rd   = 1'b1;
            state_in = stt_ring_pkg::ST_RDWAIT;
         end
         stt_ring_pkg::ST_RDWAIT: begin
            state_in = stt_ring_pkg::ST_CHECK;
         end
         stt_ring_pkg::ST_CHECK: begin
            state_in = stt_ring_pkg::ST_DONE;
            if (op_ff == stt_ring_pkg::REQ_EMIT) begin
               mem_we      = 1'b1;
               emit_cnt_in = emit_cnt_ff + 1'b1;
               if (rd_valid_ff) begin
                  ovw_cnt_in = ovw_cnt_ff + 1'b1;
               end
               res_ok_in = 1'b1;
            end else if (!rd_valid_ff || rd_tag_ff != seq_ff) begin
               res_ok_in = 1'b0;
            end else if (op_ff == stt_ring_pkg::REQ_READ) begin
               res_ok_in   = 1'b1;
               res_body_in = rd_body_ff;
            end else if (left_ff == SW'(1)) begin
               res_ok_in = 1'b1;
            end else begin
               // Next sequence of the span.
               left_in          = left_ff - 1'b1;
               seq_in           = seq_ff + 1'b1;
               rem_req.go       = 1'b1;
               rem_req.dividend = seq_ff + 1'b1;
               state_in         = stt_ring_pkg::ST_DIV;
            end
         end
         stt_ring_pkg::ST_CLEAR: begin
            vclr_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(SLOTS_MAX - 1)) begin
               state_in = (op_ff == stt_ring_pkg::REQ_RESTORE) ?
                          stt_ring_pkg::ST_DONE : stt_ring_pkg::ST_IDLE;
            end
         end
         stt_ring_pkg::ST_DONE: begin
            out_v_in = 1'b1;
            state_in = stt_ring_pkg::ST_IDLE;
         end
         default: begin
            state_in = stt_ring_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= stt_ring_pkg::ST_CLEAR;
         op_ff       <= '1;
         clr_ff      <= '0;
         next_seq_ff <= '0;
         emit_cnt_ff <= '0;
         ovw_cnt_ff  <= '0;
         drop_cnt_ff <= '0;
         out_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         op_ff       <= op_in;
         clr_ff      <= clr_in;
         next_seq_ff <= next_seq_in;
         emit_cnt_ff <= emit_cnt_in;
         ovw_cnt_ff  <= ovw_cnt_in;
         drop_cnt_ff <= drop_cnt_in;
         out_v_ff    <= out_v_in;
      end
      body_ff     <= body_in;
      seq_ff      <= seq_in;
      left_ff     <= left_in;
      idx_ff      <= idx_in;
      res_ok_ff   <= res_ok_in;
      res_asg_ff  <= res_asg_in;
      res_body_ff <= res_body_in;
      res_old_ff  <= res_old_in;
   end

   // Valid memory: swept clear or set on a store.
   always_ff @(posedge clock) begin
      if (vclr_we) begin
         valid_mem[vclr_idx] <= 1'b0;
      end else if (mem_we) begin
         valid_mem[idx_ff] <= 1'b1;
      end
      if (mem_rd) begin
         rd_valid_ff <= valid_mem[idx_ff];
      end
   end

   // Tag and body memories.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[idx_ff]  <= seq_ff;
         body_mem[idx_ff] <= body_ff;
      end
      if (mem_rd) begin
         rd_tag_ff  <= tag_mem[idx_ff];
         rd_body_ff <= body_mem[idx_ff];
      end
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_ok                = res_ok_ff;
   assign rsp_issued_seq        = res_asg_ff;
   assign rsp_read_body         = res_body_ff;
   assign rsp_oldest_retained   = res_old_ff;
   assign rsp_emitted_total     = emit_cnt_ff;
   assign rsp_overwritten_total = ovw_cnt_ff;
   assign rsp_dropped_total     = drop_cnt_ff;
endmodule
`default_nettype wire

FILE: rtl/stt_ring_rem.sv
`default_nettype none
// Restoring remainder, one quotient bit per cycle.
module stt_ring_rem (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire stt_ring_pkg::rem_req_type rem_req,
   output      stt_ring_pkg::rem_rsp_type rem_rsp
);
   localparam int SW = stt_ring_pkg::SEQ_W;
   localparam int CW = stt_ring_pkg::CAP_W;

   logic [SW-1:0] shift_ff, shift_in;
   logic [CW:0]   part_ff, part_in;
   logic [CW-1:0] div_ff, div_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW:0]   trial;

   // One shift-subtract step per cycle.
   always_comb begin
      shift_in = shift_ff;
      part_in  = part_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {part_ff[CW-1:0], shift_ff[SW-1]};
      if (rem_req.go) begin
         shift_in = rem_req.dividend;
         part_in  = '0;
         div_in   = rem_req.divisor;
         cnt_in   = 7'(SW);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[SW-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            part_in = trial - {1'b0, div_ff};
         end else begin
            part_in = trial;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      part_ff  <= part_in;
      div_ff   <= div_in;
   end

   assign rem_rsp.done = done_ff;
   assign rem_rsp.rem  = part_ff[CW-1:0];
endmodule
`default_nettype wire

FILE: rtl/stt_ring_checker.sv
`default_nettype none
module stt_ring_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [63:0] rsp_emitted_total
);
   // A result only comes while an item is in flight.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without item");

   // Accepting an item raises busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");

   // Results are single-cycle strobes.
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");

   // Emitted count never changes while idle.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy)) |-> $stable(rsp_emitted_total))
      else $error("counter moved while idle");
endmodule

bind sequence_tagged_trace_ring_core stt_ring_checker u_chk (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_emitted_total (rsp_emitted_total)
);
`default_nettype wire
